### rtl/core/hdbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder package
// Shared constants, symbol codes and the delay line control type.
// ----------------------------------------------------------------------------
package hdbn_pkg;

    // Default depth of the symbol delay line (largest zero limit supported).
    localparam int MAX_ZERO_LIMIT_DEF = 4;
    // Smallest zero limit the encoder acts on.
    localparam int MIN_ZERO_LIMIT     = 2;

    // Configuration register.
    localparam int ZERO_LIMIT_W   = 3;
    localparam int ZERO_LIMIT_RST = 3;
    localparam int ZERO_RUN_W     = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_ZERO_LIMIT = 2'd0;

    // Bipolar symbol codes.
    localparam int SYM_W = 2;
    typedef logic [SYM_W-1:0] t_sym;
    localparam t_sym SYM_ZERO = 2'd0;
    localparam t_sym SYM_POS  = 2'd1;
    localparam t_sym SYM_NEG  = 2'd2;

    // Control of the delay line: pop, push and the pushed symbol.
    typedef struct packed {
        logic pop;
        logic push;
        t_sym push_sym;
    } t_line_ctl;

endpackage

### rtl/core/hdbn_bit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn message bit channel
// Valid/ready channel that carries one message bit and its end flag.
// ----------------------------------------------------------------------------
interface hdbn_bit_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic end_of_message;

    modport source (output valid, output data_bit, output end_of_message, input ready);
    modport sink   (input valid, input data_bit, input end_of_message, output ready);
endinterface

### rtl/core/hdbn_sym_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line symbol channel
// Valid/ready channel that carries one bipolar symbol on the P and N rails.
// ----------------------------------------------------------------------------
interface hdbn_sym_if;
    logic valid;
    logic ready;
    logic pos_pulse;
    logic neg_pulse;
    logic message_last;

    modport source (output valid, output pos_pulse, output neg_pulse,
                    output message_last, input ready);
    modport sink   (input valid, input pos_pulse, input neg_pulse,
                    input message_last, output ready);
endinterface

### rtl/core/hdbn_sym_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn symbol delay line
// Shift register of symbols with a fill count; oldest entry at index zero.
// ----------------------------------------------------------------------------
module hdbn_sym_line #(
    parameter int MAX_ZL = hdbn_pkg::MAX_ZERO_LIMIT_DEF,
    localparam int FILL_W = $clog2(MAX_ZL + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hdbn_pkg::t_line_ctl   i_ctl,
    output hdbn_pkg::t_sym        o_oldest,
    output logic [FILL_W-1:0]     o_fill
);
    import hdbn_pkg::*;

    t_sym              r_sym [MAX_ZL];
    t_sym              n_sym [MAX_ZL];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] wr_idx;

    // A push after a pop lands one place lower.
    assign wr_idx = i_ctl.pop ? (r_fill - FILL_W'(1)) : r_fill;

    // Shift towards the head on a pop, then write the new symbol.
    for (genvar g = 0; g < MAX_ZL; g++) begin : g_entry
        t_sym shifted;
        if (g < MAX_ZL - 1) begin : g_mid
            assign shifted = i_ctl.pop ? r_sym[g+1] : r_sym[g];
        end else begin : g_tail
            assign shifted = r_sym[g];
        end
        assign n_sym[g] = (i_ctl.push && (wr_idx == FILL_W'(g))) ? i_ctl.push_sym : shifted;
    end

    // Fill count follows pushes and pops.
    always_comb begin
        n_fill = r_fill;
        if (i_ctl.push && !i_ctl.pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Symbol storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign o_oldest = r_sym[0];
    assign o_fill   = r_fill;

endmodule

### rtl/core/hdbn_line_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDBn line encoder
// Codes message bits into HDB2/HDB3/HDB4 bipolar symbols on P and N rails.
//
//   Port        Dir   Kind          Carries
//   i_bit       in    valid/ready   data_bit, end_of_message
//   o_sym       out   valid/ready   pos_pulse, neg_pulse, message_last
//   psel...     in    APB register  zero_limit at byte address 0
//
// In steady flow, with the result register not stalled, one bit is taken and
// one symbol given every cycle. A bit's symbol waits in the delay line for
// the limit's number of later bits before it is loaded into the result register.
// A bit that ends a message is followed by a flush of the symbols held in the
// delay line, and a lowered limit drains the surplus symbols; the single
// result register paces both, as it takes one symbol a cycle when free.
// Reset is synchronous and active low; no clearing pass is needed.
// While the result register is stalled, bits are still taken until the delay
// line holds the limit's number of symbols and the input register is full.
// ----------------------------------------------------------------------------
module hdbn_line_encoder #(
    parameter int MAX_ZERO_LIMIT = hdbn_pkg::MAX_ZERO_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hdbn_bit_if.sink                        i_bit,
    hdbn_sym_if.source                      o_sym,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hdbn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hdbn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hdbn_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hdbn_pkg::*;

    localparam int FILL_W = $clog2(MAX_ZERO_LIMIT + 1);

    // Configuration and coder state.
    logic [ZERO_LIMIT_W-1:0] r_zero_limit;
    logic [ZERO_RUN_W-1:0]   r_zero_run;
    logic [ZERO_RUN_W-1:0]   n_zero_run;
    logic                    r_last_mark_pos;
    logic                    n_last_mark_pos;
    logic                    r_last_viol_pos;
    logic                    n_last_viol_pos;
    logic                    r_flush;
    logic                    n_flush;

    // Input register.
    logic r_in_valid;
    logic r_in_bit;
    logic r_in_eom;

    // Result register.
    logic r_out_valid;
    logic r_out_pos;
    logic r_out_neg;
    logic r_out_last;

    // Delay line.
    t_line_ctl         line_ctl;
    t_sym              line_oldest;
    logic [FILL_W-1:0] line_fill;

    logic [FILL_W-1:0]     lim;
    logic [ZERO_RUN_W-1:0] zero_run_inc;
    logic                  out_free;
    logic                  act_flush;
    logic                  act_drain;
    logic                  act_proc;
    logic                  held;
    logic                  violation;
    logic                  b_apply;
    t_sym                  viol_sym;
    t_sym                  proc_sym;
    logic                  out_load;
    t_sym                  out_sym;
    logic                  out_last;
    logic                  cfg_write;

    // Configuration port: writes complete in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_ZERO_LIMIT);
    assign prdata    = (paddr == ADDR_ZERO_LIMIT)
                     ? {{(APB_DATA_W-ZERO_LIMIT_W){1'b0}}, r_zero_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_limit <= ZERO_LIMIT_W'(ZERO_LIMIT_RST);
        end else if (cfg_write) begin
            r_zero_limit <= pwdata[ZERO_LIMIT_W-1:0];
        end
    end

    // Limit clamped into the supported range.
    always_comb begin
        if (32'(r_zero_limit) > MAX_ZERO_LIMIT) begin
            lim = FILL_W'(MAX_ZERO_LIMIT);
        end else if (32'(r_zero_limit) < MIN_ZERO_LIMIT) begin
            lim = FILL_W'(MIN_ZERO_LIMIT);
        end else begin
            lim = FILL_W'(r_zero_limit);
        end
    end

    // Pick this cycle's action: flush, drain surplus, or code the held bit.
    assign out_free  = !r_out_valid || o_sym.ready;
    assign held      = (line_fill == lim);
    assign act_flush = r_flush && out_free;
    assign act_drain = !r_flush && r_in_valid && (line_fill > lim) && out_free;
    assign act_proc  = !r_flush && r_in_valid && (line_fill <= lim)
                     && (!held || out_free);

    // Input register takes a transfer whenever it is empty or the held bit moves on.
    assign i_bit.ready = !r_in_valid || act_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_bit.valid && i_bit.ready) begin
            r_in_valid <= 1'b1;
        end else if (act_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bit.valid && i_bit.ready) begin
            r_in_bit <= i_bit.data_bit;
            r_in_eom <= i_bit.end_of_message;
        end
    end

    // Symbol coding: alternate marks, violations and balancing pulses.
    assign zero_run_inc = r_zero_run + ZERO_RUN_W'(1);
    assign violation    = !r_in_bit && (32'(zero_run_inc) >= (32'(lim) + 1));
    assign viol_sym     = r_last_viol_pos ? SYM_NEG : SYM_POS;
    assign b_apply      = violation && held && (r_last_mark_pos == r_last_viol_pos);

    always_comb begin
        n_zero_run      = r_zero_run;
        n_last_mark_pos = r_last_mark_pos;
        n_last_viol_pos = r_last_viol_pos;
        n_flush         = r_flush;
        proc_sym        = SYM_ZERO;
        if (act_flush && (line_fill == FILL_W'(1))) begin
            n_flush = 1'b0;
        end
        if (act_proc) begin
            if (r_in_bit) begin
                n_zero_run      = '0;
                proc_sym        = r_last_mark_pos ? SYM_NEG : SYM_POS;
                n_last_mark_pos = !r_last_mark_pos;
            end else if (violation) begin
                n_zero_run      = '0;
                proc_sym        = viol_sym;
                n_last_viol_pos = !r_last_viol_pos;
                if (b_apply) begin
                    n_last_mark_pos = !r_last_viol_pos;
                end
            end else begin
                n_zero_run = zero_run_inc;
            end
            // End of message returns the polarity state to reset.
            if (r_in_eom) begin
                n_zero_run      = '0;
                n_last_mark_pos = 1'b0;
                n_last_viol_pos = 1'b0;
                n_flush         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run      <= '0;
            r_last_mark_pos <= 1'b0;
            r_last_viol_pos <= 1'b0;
            r_flush         <= 1'b0;
        end else begin
            r_zero_run      <= n_zero_run;
            r_last_mark_pos <= n_last_mark_pos;
            r_last_viol_pos <= n_last_viol_pos;
            r_flush         <= n_flush;
        end
    end

    // Delay line control.
    assign line_ctl.pop      = act_flush || act_drain || (act_proc && held);
    assign line_ctl.push     = act_proc;
    assign line_ctl.push_sym = proc_sym;

    hdbn_sym_line #(
        .MAX_ZL (MAX_ZERO_LIMIT)
    ) u_sym_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (line_ctl),
        .o_oldest (line_oldest),
        .o_fill   (line_fill)
    );

    // The oldest symbol leaves; a balancing pulse overwrites it on the way out.
    assign out_load = line_ctl.pop;
    assign out_sym  = b_apply ? viol_sym : line_oldest;
    assign out_last = act_flush && (line_fill == FILL_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_sym.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos  <= (out_sym == SYM_POS);
            r_out_neg  <= (out_sym == SYM_NEG);
            r_out_last <= out_last;
        end
    end

    assign o_sym.valid        = r_out_valid;
    assign o_sym.pos_pulse    = r_out_pos;
    assign o_sym.neg_pulse    = r_out_neg;
    assign o_sym.message_last = r_out_last;

`ifndef ASSERT_OFF
    // The last flushed symbol empties the line and ends the flush.
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_flush && (line_fill == FILL_W'(1)) |=> !r_flush && (line_fill == '0))
        else $error("flush did not end on the last held symbol");

    // No new bit is coded while the line is being flushed.
    a_no_code_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !act_proc)
        else $error("bit coded during flush");

    // Steady flow keeps the line at the limit.
    a_steady_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_proc && held && !r_in_eom |=> line_fill == $past(line_fill))
        else $error("fill count moved in steady flow");

    // A symbol never drives both rails.
    a_one_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_pos && r_out_neg))
        else $error("both rails driven");
`endif

endmodule
